/* hw/rtl/text_mode_terminal_writer_macros.svh */
// Assertion macros shared by the terminal writer RTL.
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clk edge while arst_n is high.
`define TMTW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tmtw assertion failed");

// Checked on every rising clk edge, reset included.
`define TMTW_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("tmtw assertion failed");

`else

`define TMTW_ASSERT(lbl, prop)

`define TMTW_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hw/rtl/tmtw_pkg.sv */
// Types and constants of the text-mode terminal writer.
package tmtw_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BLANK     = 8'h20;

	localparam int unsigned TAB_STEP = 3;

	localparam logic [3:0] RESET_BG = 4'h0;
	localparam logic [3:0] RESET_FG = 4'h7;

	localparam logic REG_BACKGROUND = 1'b0;
	localparam logic REG_FOREGROUND = 1'b1;

	// One sweep write in flight between issue and the memory write port.
	typedef struct packed {
		logic        vld;
		logic        from_mem;
		logic [15:0] data;
	} sweep_s1_t;

	function automatic logic [15:0] make_cell(logic [3:0] bg, logic [3:0] fg, logic [7:0] ch);
		return {bg, fg, ch};
	endfunction

	localparam logic [15:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_BLANK};

endpackage

/* hw/rtl/tmtw_cell_mem.sv */
// Cell store: one write port, one read port with registered read data.
module tmtw_cell_mem #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/text_mode_terminal_writer.sv */
// Top level of the text-mode terminal writer.
//
// Input channel (in_valid/in_ready) carries op, char_code, read_row, read_col;
// every accepted item yields exactly one transfer on the output channel
// (out_valid/out_ready) with cell_data, the cursor after the step and scrolled.
// Put (no scroll), read and the unused op: the result is loaded into the output
// register from the done state, and the next item is taken after that.
// Scroll and clear walk the whole cell store, one cell per cycle through the
// single write port, before the result is loaded and the next item is taken.
// Colour registers sit on the APB port: background at 0x0, foreground at 0x4;
// colours are sampled when a cell is written.
// After reset the store is filled with blank cells (0x0720); in_ready stays low
// until the fill is done, and register writes are taken meanwhile.
// A stalled output holds its result; one further item may be accepted and
// worked on, and it completes once the output register is free.
module text_mode_terminal_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  char_code,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_data,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic        scrolled
);

	import tmtw_pkg::*;

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int CELL_AW  = $clog2(CELLS);
	localparam int RW       = $clog2(ROWS);
	localparam int CW       = $clog2(COLUMNS);
	localparam int COPY_END = CELLS - COLUMNS;

	localparam logic [RW:0]        ROWS_W     = (RW + 1)'(ROWS);
	localparam logic [RW:0]        LAST_ROW   = (RW + 1)'(ROWS - 1);
	localparam logic [CW+1:0]      COLS_W     = (CW + 2)'(COLUMNS);
	localparam logic [CW+1:0]      LAST_COL   = (CW + 2)'(COLUMNS - 1);
	localparam logic [CW+1:0]      TAB_W      = (CW + 2)'(TAB_STEP);
	localparam logic [CELL_AW-1:0] COLS_A     = CELL_AW'(COLUMNS);
	localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);
	localparam logic [CELL_AW-1:0] COPY_END_A = CELL_AW'(COPY_END);

	// Configuration registers
	logic [3:0] bg_q;
	logic [3:0] fg_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= RESET_BG;
			fg_q <= RESET_FG;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BACKGROUND: bg_q <= pwdata[3:0];
				REG_FOREGROUND: fg_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BACKGROUND: prdata = {28'd0, bg_q};
			REG_FOREGROUND: prdata = {28'd0, fg_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Control state
	state_t             state_q, state_d;
	logic [CELL_AW-1:0] cnt_q, cnt_d;
	logic               copy_q, copy_d;
	logic               init_q, init_d;
	logic [RW-1:0]      row_q, row_d;
	logic [CW-1:0]      col_q, col_d;
	logic               scrolled_q, scrolled_d;
	logic               from_mem_q, from_mem_d;
	sweep_s1_t          sw_s1, sw_d;
	logic [CELL_AW-1:0] sw_addr_s1, sw_addr_d;
	logic               out_valid_q;
	logic [15:0]        cell_q;
	logic [4:0]         cur_row_q;
	logic [6:0]         cur_col_q;
	logic               scr_out_q;

	// Memory ports
	logic               mem_wr_en;
	logic [CELL_AW-1:0] mem_wr_addr;
	logic [15:0]        mem_wr_data;
	logic               mem_rd_en;
	logic [CELL_AW-1:0] mem_rd_addr;
	logic [15:0]        mem_rd_data;

	// Put decode
	logic               accept;
	logic               load_out;
	logic [CELL_AW-1:0] cur_addr;
	logic [CELL_AW-1:0] req_addr;
	logic               req_in_range;
	logic [RW:0]        nrow;
	logic [CW+1:0]      ncol;
	logic               put_wr;
	logic [CELL_AW-1:0] put_addr;
	logic [15:0]        put_data;
	logic               put_scroll;
	logic [15:0]        blank_cell;

	assign in_ready   = (state_q == ST_IDLE) && !sw_s1.vld;
	assign accept     = in_valid && in_ready;
	assign blank_cell = make_cell(bg_q, fg_q, CH_BLANK);
	assign cur_addr   = CELL_AW'(row_q) * COLS_A + CELL_AW'(col_q);

	assign req_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
	assign req_addr     = CELL_AW'(int'(read_row) * COLUMNS + int'(read_col));

	always_comb begin
		nrow       = {1'b0, row_q};
		ncol       = {2'b00, col_q};
		put_wr     = 1'b0;
		put_addr   = cur_addr;
		put_data   = make_cell(bg_q, fg_q, char_code);
		put_scroll = 1'b0;
		case (char_code)
			CH_NEWLINE: begin
				nrow = nrow + 1'b1;
				ncol = '0;
			end
			CH_TAB: begin
				ncol = ncol + TAB_W;
			end
			CH_BACKSPACE: begin
				if (row_q != '0 || col_q != '0) begin
					put_wr   = 1'b1;
					put_addr = cur_addr - 1'b1;
					put_data = blank_cell;
					if (col_q == '0) begin
						ncol = LAST_COL;
						nrow = nrow - 1'b1;
					end else begin
						ncol = ncol - 1'b1;
					end
				end
			end
			default: begin
				put_wr = 1'b1;
				ncol   = ncol + 1'b1;
			end
		endcase
		if (ncol >= COLS_W) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end
		if (nrow >= ROWS_W) begin
			nrow       = LAST_ROW;
			put_scroll = 1'b1;
		end
	end

	// Next state and datapath control
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		copy_d      = copy_q;
		init_d      = init_q;
		row_d       = row_q;
		col_d       = col_q;
		scrolled_d  = scrolled_q;
		from_mem_d  = from_mem_q;
		sw_d        = '0;
		sw_addr_d   = cnt_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = req_addr;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					scrolled_d = 1'b0;
					from_mem_d = 1'b0;
					state_d    = ST_DONE;
					cnt_d      = '0;
					copy_d     = 1'b0;
					case (op_t'(op))
						OP_PUT: begin
							row_d      = nrow[RW-1:0];
							col_d      = ncol[CW-1:0];
							scrolled_d = put_scroll;
							if (put_scroll) begin
								state_d = ST_SWEEP;
								copy_d  = 1'b1;
							end
						end
						OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							state_d = ST_SWEEP;
						end
						OP_READ: begin
							mem_rd_en  = req_in_range;
							from_mem_d = req_in_range;
						end
						default: ;
					endcase
				end
			end
			ST_SWEEP: begin
				sw_d.vld      = 1'b1;
				sw_d.from_mem = copy_q && (cnt_q < COPY_END_A);
				sw_d.data     = init_q ? RESET_BLANK : blank_cell;
				mem_rd_en     = sw_d.from_mem;
				mem_rd_addr   = cnt_q + COLS_A;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == LAST_CELL) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
					init_d  = 1'b0;
				end
			end
			ST_DONE: begin
				load_out = !out_valid_q || out_ready;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			cnt_q       <= '0;
			copy_q      <= 1'b0;
			init_q      <= 1'b1;
			row_q       <= '0;
			col_q       <= '0;
			scrolled_q  <= 1'b0;
			from_mem_q  <= 1'b0;
			sw_s1       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			copy_q     <= copy_d;
			init_q     <= init_d;
			row_q      <= row_d;
			col_q      <= col_d;
			scrolled_q <= scrolled_d;
			from_mem_q <= from_mem_d;
			sw_s1      <= sw_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_addr_s1 <= sw_addr_d;
		if (load_out) begin
			cell_q    <= from_mem_q ? mem_rd_data : 16'd0;
			cur_row_q <= 5'(row_q);
			cur_col_q <= 7'(col_q);
			scr_out_q <= scrolled_q;
		end
	end

	// Sweep writes own the port; puts are only accepted with no sweep write pending.
	always_comb begin
		if (sw_s1.vld) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = sw_addr_s1;
			mem_wr_data = sw_s1.from_mem ? mem_rd_data : sw_s1.data;
		end else begin
			mem_wr_en   = accept && (op_t'(op) == OP_PUT) && put_wr;
			mem_wr_addr = put_addr;
			mem_wr_data = put_data;
		end
	end

	tmtw_cell_mem #(
		.DEPTH(CELLS)
	) u_cell_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign out_valid  = out_valid_q;
	assign cell_data  = cell_q;
	assign cursor_row = cur_row_q;
	assign cursor_col = cur_col_q;
	assign scrolled   = scr_out_q;

`include "text_mode_terminal_writer_macros.svh"

	`TMTW_ASSERT(a_cursor_range, (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))
	`TMTW_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_q != ST_IDLE))
	`TMTW_ASSERT(a_scroll_last_row, (state_q == ST_DONE && scrolled_q) |-> (row_d == row_q && int'(row_q) == ROWS - 1))
	`TMTW_ASSERT(a_sweep_count_range, (state_q == ST_SWEEP) |-> (int'(cnt_q) < CELLS))
	`TMTW_ASSERT(a_copy_source_written, (sw_s1.vld && sw_s1.from_mem) |-> $past(mem_rd_en))

endmodule

/* test/tb.sv */
// Self-checking testbench for the text-mode terminal writer: random handshakes, colour phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmtw_pkg::*;

	localparam int COLS       = 80;
	localparam int LINES      = 25;
	localparam int CELLS      = COLS * LINES;
	localparam int LONG_HOLD  = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_ITEMS = 70;

	localparam logic [2:0] ADDR_BACKGROUND = {REG_BACKGROUND, 2'b00};
	localparam logic [2:0] ADDR_FOREGROUND = {REG_FOREGROUND, 2'b00};

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [4:0] rd_row;
		logic [6:0] rd_col;
	} term_item_t;

	typedef struct packed {
		logic [15:0] data;
		logic [4:0]  row;
		logic [6:0]  col;
		logic        scr;
	} term_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [7:0]  char_code = '0;
	logic [4:0]  read_row = '0;
	logic [6:0]  read_col = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] cell_data;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic        scrolled;

	text_mode_terminal_writer #(
		.COLUMNS(COLS),
		.ROWS(LINES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.char_code(char_code),
		.read_row(read_row),
		.read_col(read_col),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_data(cell_data),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled(scrolled)
	);

	always #10 clk = ~clk;

	// Shadow of the screen, cursor and colours
	logic [15:0]  screen_copy [CELLS];
	int unsigned  cur_row = 0;
	int unsigned  cur_col = 0;
	logic [3:0]   bg_color = RESET_BG;
	logic [3:0]   fg_color = RESET_FG;

	term_item_t   queued_items [$];
	term_result_t awaited_results [$];
	term_item_t   cur_item;

	int unsigned  send_idle_max = 0;
	int unsigned  recv_idle_max = 0;
	int unsigned  send_wait = 0;
	int unsigned  recv_wait = 0;
	int unsigned  long_hold_reqs = 0;
	int unsigned  long_hold_seen = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  stall_cycles = 0;

	function automatic logic [15:0] cell_word(logic [7:0] ch);
		return {bg_color, fg_color, ch};
	endfunction

	function automatic void blank_screen();
		foreach (screen_copy[i]) screen_copy[i] = cell_word(CH_BLANK);
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLS; i++) screen_copy[i] = screen_copy[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++) screen_copy[i] = cell_word(CH_BLANK);
	endfunction

	function automatic logic write_char(logic [7:0] ch);
		int unsigned pos;
		pos = cur_row * COLS + cur_col;
		if (ch == CH_NEWLINE) begin
			cur_row++;
			cur_col = 0;
		end else if (ch == CH_TAB) begin
			cur_col += TAB_STEP;
		end else if (ch == CH_BACKSPACE) begin
			if (pos == 0)
				return 1'b0;
			screen_copy[pos - 1] = cell_word(CH_BLANK);
			if (cur_col == 0) begin
				cur_col = COLS - 1;
				cur_row--;
			end else begin
				cur_col--;
			end
		end else begin
			screen_copy[pos] = cell_word(ch);
			cur_col++;
		end
		if (cur_col >= COLS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= LINES) begin
			scroll_screen();
			cur_row = LINES - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic term_result_t next_terminal_result(term_item_t it);
		term_result_t res;
		res = '0;
		case (it.op)
			OP_PUT: res.scr = write_char(it.ch);
			OP_CLEAR: begin
				blank_screen();
				cur_row = 0;
				cur_col = 0;
			end
			OP_READ: begin
				if (it.rd_row < LINES && it.rd_col < COLS)
					res.data = screen_copy[it.rd_row * COLS + it.rd_col];
			end
			default: ;
		endcase
		res.row = 5'(cur_row);
		res.col = 7'(cur_col);
		return res;
	endfunction

	// Input side
	always @(posedge clk) begin
		logic offering;
		offering = in_valid;
		if (in_valid && in_ready) begin
			awaited_results.push_back(next_terminal_result(cur_item));
			offering = 1'b0;
			send_wait = $urandom_range(0, send_idle_max);
		end
		if (!offering && arst_n) begin
			if (send_wait > 0) begin
				send_wait--;
			end else if (queued_items.size() > 0) begin
				cur_item = queued_items.pop_front();
				op <= cur_item.op;
				char_code <= cur_item.ch;
				read_row <= cur_item.rd_row;
				read_col <= cur_item.rd_col;
				offering = 1'b1;
			end
		end
		in_valid <= offering;
	end

	// Output side
	always @(posedge clk) begin
		logic         ready_next;
		term_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: cell=%h row=%0d col=%0d scrolled=%0b",
						cell_data, cursor_row, cursor_col, scrolled);
			end else begin
				want = awaited_results.pop_front();
				if (want.data !== cell_data || want.row !== cursor_row ||
						want.col !== cursor_col || want.scr !== scrolled) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected cell=%h row=%0d col=%0d scrolled=%0b, got cell=%h row=%0d col=%0d scrolled=%0b",
							want.data, want.row, want.col, want.scr,
							cell_data, cursor_row, cursor_col, scrolled);
				end
			end
			recv_wait = $urandom_range(0, recv_idle_max);
		end
		if (long_hold_seen != long_hold_reqs) begin
			long_hold_seen = long_hold_reqs;
			recv_wait = LONG_HOLD;
		end
		if (recv_wait > 0) begin
			recv_wait--;
			ready_next = 1'b0;
		end else begin
			ready_next = 1'b1;
		end
		out_ready <= ready_next;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void add_item(op_t o, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
		term_item_t it;
		it.op = o;
		it.ch = ch;
		it.rd_row = r;
		it.rd_col = c;
		queued_items.push_back(it);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_NEWLINE || c == CH_TAB || c == CH_BACKSPACE);
		return c;
	endfunction

	function automatic void add_read();
		if ($urandom_range(0, 7) == 0)
			add_item(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
		else
			add_item(OP_READ, 8'($urandom), 5'($urandom_range(0, LINES - 1)),
				7'($urandom_range(0, COLS - 1)));
	endfunction

	function automatic void add_mixed_item();
		int unsigned r;
		int unsigned k;
		logic [7:0]  ch;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			add_item(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
		end else if (r < 4) begin
			add_item(OP_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
		end else if (r < 16) begin
			add_read();
		end else begin
			k = $urandom_range(0, 99);
			if (k < 6)
				ch = CH_NEWLINE;
			else if (k < 12)
				ch = CH_TAB;
			else if (k < 22)
				ch = CH_BACKSPACE;
			else
				ch = 8'($urandom_range(0, 255));
			add_item(OP_PUT, ch, 5'($urandom), 7'($urandom));
		end
	endfunction

	// Returns the number of items queued
	function automatic int add_random_chunk();
		int n;
		int m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				n = $urandom_range(10, 30);
				repeat (n) add_mixed_item();
			end
			4, 5, 6: begin
				n = $urandom_range(40, 100);
				repeat (n) add_item(OP_PUT, plain_char(), 5'($urandom), 7'($urandom));
				repeat (2) add_read();
				n += 2;
			end
			7, 8: begin
				n = $urandom_range(5, 30);
				m = $urandom_range(3, 30);
				repeat (n) add_item(OP_PUT, CH_TAB, 5'($urandom), 7'($urandom));
				repeat (m) add_item(OP_PUT, CH_BACKSPACE, 5'($urandom), 7'($urandom));
				repeat (3) add_read();
				n += m + 3;
			end
			default: begin
				n = $urandom_range(3, 15);
				repeat (n) add_item(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
				repeat (4) add_read();
				n += 4;
			end
		endcase
		return n;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (queued_items.size() != 0 || in_valid || awaited_results.size() != 0);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [3:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {28'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_colors(logic [3:0] bg, logic [3:0] fg);
		write_reg(ADDR_BACKGROUND, bg);
		write_reg(ADDR_FOREGROUND, fg);
		@(negedge clk);
		bg_color = bg;
		fg_color = fg;
	endtask

	initial begin
		int queued;
		foreach (screen_copy[i]) screen_copy[i] = RESET_BLANK;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		send_idle_max = 19;
		recv_idle_max = 19;
		add_item(OP_READ,  8'h00, 5'd0, 7'd0);
		add_item(OP_PUT,   CH_BACKSPACE, 5'd0, 7'd0);
		add_item(OP_READ,  8'h00, 5'd24, 7'd79);
		add_item(OP_PUT,   8'h00, 5'd0, 7'd0);
		add_item(OP_PUT,   8'hFF, 5'd31, 7'd127);
		add_item(OP_PUT,   8'h41, 5'd0, 7'd0);
		add_item(OP_PUT,   CH_TAB, 5'd0, 7'd0);
		add_item(OP_PUT,   CH_BACKSPACE, 5'd0, 7'd0);
		add_item(OP_PUT,   CH_NEWLINE, 5'd0, 7'd0);
		add_item(OP_PUT,   CH_BACKSPACE, 5'd0, 7'd0);
		add_item(OP_PUT,   8'h7F, 5'd0, 7'd0);
		add_item(OP_READ,  8'h00, 5'd0, 7'd79);
		add_item(OP_READ,  8'h00, 5'd0, 7'd1);
		add_item(OP_READ,  8'h00, 5'd0, 7'd0);
		add_item(OP_READ,  8'h00, 5'd0, 7'd5);
		add_item(OP_READ,  8'h00, 5'd25, 7'd0);
		add_item(OP_READ,  8'h00, 5'd0, 7'd80);
		add_item(OP_READ,  8'hFF, 5'd31, 7'd127);
		add_item(OP_NONE,  8'hFF, 5'd31, 7'd127);
		add_item(OP_PUT,   CH_TAB, 5'd0, 7'd0);
		add_item(OP_PUT,   8'h7A, 5'd0, 7'd0);
		add_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
		add_item(OP_READ,  8'h00, 5'd0, 7'd0);
		add_item(OP_READ,  8'h00, 5'd1, 7'd0);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_colors(4'hF, 4'h0);
				1: set_colors(4'h0, 4'hF);
				2: set_colors(4'hF, 4'hF);
				3: set_colors(4'h0, 4'h0);
				4: set_colors(4'($urandom), 4'($urandom));
				default: set_colors(RESET_BG, RESET_FG);
			endcase
			case (phase)
				0, 4: begin send_idle_max = 19; recv_idle_max = 19; end
				1, 5: begin send_idle_max = 0;  recv_idle_max = 0;  end
				2: begin send_idle_max = 19; recv_idle_max = 0;  end
				default: begin send_idle_max = 0;  recv_idle_max = 19; end
			endcase
			queued = 0;
			while (queued < PHASE_ITEMS) queued += add_random_chunk();
			// output held off while the input keeps pushing
			if (phase == 1)
				long_hold_reqs++;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
